### hdl/swec_pkg.sv
// Shared constants and types for the sliding window event counter.
// No dependencies. Used by the interfaces and the top level.
package swec_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OCC_W        = $clog2(STORE_DEPTH + 1);
    localparam int TS_W         = 32;
    localparam int WINDOW_W     = 12;
    localparam int COUNT_W      = 13;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 12'd3000;

    typedef logic [TS_W-1:0]     ts_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [OCC_W-1:0]    occ_t;
    typedef logic [WINDOW_W-1:0] window_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_APPEND
    } state_t;

endpackage

### hdl/swec_ifs.sv
// Valid/ready channel interfaces for the sliding window event counter.
// Depends on swec_pkg for payload types.
interface swec_event_if;
    logic            valid;
    logic            ready;
    swec_pkg::ts_t   timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink   (input valid, input timestamp, output ready);
endinterface

interface swec_result_if;
    logic             valid;
    logic             ready;
    swec_pkg::count_t event_count;
    logic             overflow;

    modport source (output valid, output event_count, output overflow, input ready);
    modport sink   (input valid, input event_count, input overflow, output ready);
endinterface

### hdl/sliding_window_event_counter.sv
// Sliding window event counter: timestamp FIFO in block RAM with front pruning.
// Depends on swec_pkg and the channel interfaces in swec_ifs.sv.
//
// Usage:
//   events  - sink channel, one word per event carrying a non-decreasing timestamp.
//   results - source channel, one word per event: event_count and overflow.
//   cfg_we / cfg_wdata - writes window_length (reset 3000); write only while idle.
// Operation: the timestamp RAM (one write, one registered read port) holds the
//   FIFO. On accept the head entry is read; each following cycle compares the
//   read data against timestamp - window_length (clamped at zero) and, if
//   older, pops it and reads the next head. Then the new timestamp is written
//   at the tail unless the store is full, in which case overflow is set.
// Timing: one RAM compare per cycle while pruning, with a pop on each older head;
//   the result register loads in the append state, and the block is idle and
//   takes the next word in the same cycle that the result becomes valid.
// Reset: pointers and occupancy clear, window returns to 3000; RAM contents
//   need no clearing because only occupied entries are read.
// Stall: the result sits in an output register; the block accepts and prunes
//   the next event while it waits, and holds before the append until the
//   previous result has been taken.
module sliding_window_event_counter (
    input  logic                    clk,
    input  logic                    rst_n,
    swec_event_if.sink              events,
    swec_result_if.source           results,
    input  logic                    cfg_we,
    input  swec_pkg::window_t       cfg_wdata
);

    // timestamp store
    swec_pkg::ts_t     mem [swec_pkg::STORE_DEPTH];
    swec_pkg::ts_t     rdata_reg;
    swec_pkg::addr_t   rd_addr;

    swec_pkg::state_t  state_reg, state_next;
    swec_pkg::addr_t   head_reg, head_next;
    swec_pkg::addr_t   tail_reg, tail_next;
    swec_pkg::occ_t    occ_reg, occ_next;
    swec_pkg::window_t window_reg;
    swec_pkg::ts_t     ts_reg;
    swec_pkg::ts_t     lower_reg;
    swec_pkg::ts_t     lower_calc;

    logic              out_valid_reg;
    swec_pkg::count_t  count_reg;
    logic              ovf_reg;

    logic              accept;
    logic              older;
    logic              pop;
    logic              push;
    logic              load_out;
    logic              out_free;
    logic              occ_one;
    logic              occ_full;

    function automatic swec_pkg::addr_t inc_ptr(input swec_pkg::addr_t p);
        inc_ptr = (p == swec_pkg::addr_t'(swec_pkg::STORE_DEPTH - 1))
                  ? '0 : p + swec_pkg::addr_t'(1);
    endfunction

    assign accept   = events.valid && events.ready;
    assign older    = rdata_reg < lower_reg;
    assign out_free = !out_valid_reg || results.ready;
    assign occ_one  = occ_reg == swec_pkg::occ_t'(1);
    assign occ_full = occ_reg == swec_pkg::occ_t'(swec_pkg::STORE_DEPTH);

    // lower bound of the window, clamped at zero
    assign lower_calc = (events.timestamp >= swec_pkg::ts_t'(window_reg))
                        ? events.timestamp - swec_pkg::ts_t'(window_reg) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swec_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (occ_reg != '0) ? swec_pkg::ST_CHECK : swec_pkg::ST_APPEND;
                end
            end
            swec_pkg::ST_CHECK:
            begin
                if (!older || occ_one)
                begin
                    state_next = swec_pkg::ST_APPEND;
                end
            end
            swec_pkg::ST_APPEND:
            begin
                if (out_free)
                begin
                    state_next = swec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swec_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        events.ready = 1'b0;
        pop          = 1'b0;
        push         = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            swec_pkg::ST_IDLE:
            begin
                events.ready = 1'b1;
            end
            swec_pkg::ST_CHECK:
            begin
                pop = older;
            end
            swec_pkg::ST_APPEND:
            begin
                load_out = out_free;
                push     = out_free && !occ_full;
            end
            default:
            begin
                events.ready = 1'b0;
            end
        endcase
    end

    // pointer and occupancy updates
    always_comb
    begin
        head_next = pop  ? inc_ptr(head_reg) : head_reg;
        tail_next = push ? inc_ptr(tail_reg) : tail_reg;
        occ_next  = occ_reg;
        if (pop)
        begin
            occ_next = occ_reg - swec_pkg::occ_t'(1);
        end
        else if (push)
        begin
            occ_next = occ_reg + swec_pkg::occ_t'(1);
        end
    end

    // read the head; on a pop, read ahead to the next head
    assign rd_addr = head_next;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (push)
        begin
            mem[tail_reg] <= ts_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swec_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            window_reg    <= swec_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg    <= events.timestamp;
            lower_reg <= lower_calc;
        end
        if (load_out)
        begin
            count_reg <= swec_pkg::count_t'(occ_next);
            ovf_reg   <= occ_full;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.event_count = count_reg;
    assign results.overflow    = ovf_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= swec_pkg::occ_t'(swec_pkg::STORE_DEPTH))
        else $error("occupancy above store depth");

    a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == swec_pkg::ST_CHECK |-> occ_reg != '0)
        else $error("pruning an empty store");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.overflow |->
            results.event_count == swec_pkg::count_t'(swec_pkg::STORE_DEPTH))
        else $error("overflow without a full store");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !events.ready)
        else $error("second word accepted while one is in work");
`endif

endmodule
